// ===== sv/ttb_pkg.sv =====
`default_nettype none

package ttb_pkg;

  // Field widths
  localparam int IDX_W   = 10;
  localparam int POS_W   = 32;
  localparam int TEX_W   = 18;
  localparam int EXT_W   = 17;
  localparam int VTX_W   = 3 * POS_W + 2 * TEX_W;

  // Datapath widths
  localparam int EDGE_W  = POS_W + 1;
  localparam int DUV_W   = TEX_W + 1;
  localparam int DET_W   = 2 * DUV_W + 1;
  localparam int VEC_W   = 53;
  localparam int MOP_W   = 34;
  localparam int PROD_W  = 2 * MOP_W;
  localparam int NORM_B  = 30;
  localparam int FAST_SH = 4;
  localparam int SQ_W    = 62;
  localparam int ROOT_W  = 63;
  localparam int LEN_W   = 32;
  localparam int REM_W   = 47;
  localparam int QUO_W   = 15;
  localparam int UNIT_W  = 16;
  localparam int DIV_STEPS = 15;
  localparam int CNT_W   = 4;

  // Product pair codes: determinant, then tangent x/y/z, then bitangent x/y/z
  localparam logic [2:0] PAIR_DET  = 3'd0;
  localparam logic [2:0] PAIR_T0   = 3'd1;
  localparam logic [2:0] PAIR_T2   = 3'd3;
  localparam logic [2:0] PAIR_B0   = 3'd4;
  localparam logic [2:0] PAIR_LAST = 3'd6;

  typedef struct packed {
    logic       vtx_wr;
    logic       tri_load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       diff_en;
    logic       mul_en;
    logic       sq_mode;
    logic [2:0] pair;
    logic       half;
    logic [1:0] sq_idx;
    logic       mwr;
    logic       vec;
    logic       nload;
    logic       nshift;
    logic       sum_clr;
    logic       sum_acc;
    logic       sinit;
    logic       sstep;
    logic       dinit;
    logic       dstep;
    logic       dstore;
    logic       out_load;
    logic       deg;
  } ttb_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic mag_zero;
    logic norm_done;
    logic bit_one;
  } ttb_sts_t;

endpackage

`default_nettype wire

// ===== sv/ttb_dp.sv =====
`default_nettype none

module ttb_dp import ttb_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         vertex_index,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic signed [TEX_W-1:0]  tex_u,
  input  logic signed [TEX_W-1:0]  tex_v,
  input  logic [IDX_W-1:0]         corner_a,
  input  logic [IDX_W-1:0]         corner_b,
  input  logic [IDX_W-1:0]         corner_c,
  input  ttb_cmd_t                 cmd,
  output ttb_sts_t                 sts,
  output logic signed [UNIT_W-1:0] tangent_x,
  output logic signed [UNIT_W-1:0] tangent_y,
  output logic signed [UNIT_W-1:0] tangent_z,
  output logic signed [UNIT_W-1:0] bitangent_x,
  output logic signed [UNIT_W-1:0] bitangent_y,
  output logic signed [UNIT_W-1:0] bitangent_z,
  output logic                     degenerate,
  output logic [IDX_W-1:0]         out_corner_a,
  output logic [IDX_W-1:0]         out_corner_b,
  output logic [IDX_W-1:0]         out_corner_c
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

  // Vertex store
  logic [VTX_W-1:0] vmem [VERTEX_DEPTH];
  logic [VTX_W-1:0] rdata_r;
  logic             oob_r;

  logic [IDX_W-1:0] corner_r [3];
  logic [EXT_W-1:0] wr_ext, rd_ext;
  logic             wr_ok, rd_oob;

  logic signed [POS_W-1:0]  px_r [3];
  logic signed [POS_W-1:0]  py_r [3];
  logic signed [POS_W-1:0]  pz_r [3];
  logic signed [TEX_W-1:0]  tu_r [3];
  logic signed [TEX_W-1:0]  tv_r [3];

  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [DUV_W-1:0]  du1_r, dv1_r, du2_r, dv2_r;

  logic signed [MOP_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [VEC_W-1:0]  hold_r, pdiff;
  logic [1:0]               pidx;
  logic signed [DET_W-1:0]  det_r;
  logic signed [VEC_W-1:0]  tvec_r [3];
  logic signed [VEC_W-1:0]  bvec_r [3];

  logic [VEC_W-1:0]         mag_r [3];
  logic                     sgn_r [3];
  logic signed [VEC_W-1:0]  vsel [3];
  logic                     any_big;

  logic [SQ_W-1:0]          sum_r;
  logic [ROOT_W-1:0]        x_r, root_r, bit_r, trial;
  logic [LEN_W-1:0]         len;

  logic [REM_W-1:0]         dsh_r;
  logic [REM_W-1:0]         rem_r [3];
  logic [QUO_W-1:0]         q_r [3];
  logic signed [UNIT_W-1:0] tun_r [3];
  logic signed [UNIT_W-1:0] bun_r [3];

  // Store write on a load word; out-of-range slots are dropped
  assign wr_ext = EXT_W'(vertex_index);
  assign wr_ok  = wr_ext < EXT_W'(VERTEX_DEPTH);
  assign rd_ext = EXT_W'(corner_r[cmd.rd_sel]);
  assign rd_oob = rd_ext >= EXT_W'(VERTEX_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.vtx_wr && wr_ok) begin
      vmem[wr_ext[AW-1:0]] <= {tex_v, tex_u, pos_z, pos_y, pos_x};
    end
    if (cmd.rd_en) begin
      rdata_r <= vmem[rd_ext[AW-1:0]];
      oob_r   <= rd_oob;
    end
  end

  // Hold corners of the current triangle
  always_ff @(posedge clk) begin
    if (cmd.tri_load) begin
      corner_r[0] <= corner_a;
      corner_r[1] <= corner_b;
      corner_r[2] <= corner_c;
    end
  end

  // Capture one corner's vertex; out-of-range corners read as zero
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      px_r[cmd.cap_sel] <= oob_r ? '0 : rdata_r[POS_W-1:0];
      py_r[cmd.cap_sel] <= oob_r ? '0 : rdata_r[2*POS_W-1:POS_W];
      pz_r[cmd.cap_sel] <= oob_r ? '0 : rdata_r[3*POS_W-1:2*POS_W];
      tu_r[cmd.cap_sel] <= oob_r ? '0 : rdata_r[3*POS_W+TEX_W-1:3*POS_W];
      tv_r[cmd.cap_sel] <= oob_r ? '0 : rdata_r[VTX_W-1:3*POS_W+TEX_W];
    end
  end

  // Edges and UV deltas
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      e1_r[0] <= EDGE_W'(px_r[1]) - EDGE_W'(px_r[0]);
      e1_r[1] <= EDGE_W'(py_r[1]) - EDGE_W'(py_r[0]);
      e1_r[2] <= EDGE_W'(pz_r[1]) - EDGE_W'(pz_r[0]);
      e2_r[0] <= EDGE_W'(px_r[2]) - EDGE_W'(px_r[0]);
      e2_r[1] <= EDGE_W'(py_r[2]) - EDGE_W'(py_r[0]);
      e2_r[2] <= EDGE_W'(pz_r[2]) - EDGE_W'(pz_r[0]);
      du1_r   <= DUV_W'(tu_r[1]) - DUV_W'(tu_r[0]);
      dv1_r   <= DUV_W'(tv_r[1]) - DUV_W'(tv_r[0]);
      du2_r   <= DUV_W'(tu_r[2]) - DUV_W'(tu_r[0]);
      dv2_r   <= DUV_W'(tv_r[2]) - DUV_W'(tv_r[0]);
    end
  end

  // Select multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    pidx = 2'(cmd.pair - PAIR_T0);
    unique case (cmd.pair) inside
      PAIR_DET: begin
        op_a = cmd.half ? MOP_W'(dv1_r) : MOP_W'(du1_r);
        op_b = cmd.half ? MOP_W'(du2_r) : MOP_W'(dv2_r);
      end
      [PAIR_T0:PAIR_T2]: begin
        pidx = 2'(cmd.pair - PAIR_T0);
        op_a = cmd.half ? MOP_W'(dv1_r) : MOP_W'(dv2_r);
        op_b = cmd.half ? MOP_W'(e2_r[pidx]) : MOP_W'(e1_r[pidx]);
      end
      [PAIR_B0:PAIR_LAST]: begin
        pidx = 2'(cmd.pair - PAIR_B0);
        op_a = cmd.half ? MOP_W'(du2_r) : MOP_W'(du1_r);
        op_b = cmd.half ? MOP_W'(e1_r[pidx]) : MOP_W'(e2_r[pidx]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    if (cmd.sq_mode) begin
      op_a = $signed({(MOP_W-NORM_B)'(0), mag_r[cmd.sq_idx][NORM_B-1:0]});
      op_b = op_a;
    end
  end

  assign prod_nxt = op_a * op_b;
  assign pdiff    = hold_r - prod_r[VEC_W-1:0];

  // Multiply, then subtract the pair into det, T or B
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      if (cmd.half) begin
        hold_r <= prod_r[VEC_W-1:0];
      end
    end
    if (cmd.mwr) begin
      unique case (cmd.pair) inside
        PAIR_DET:             det_r <= pdiff[DET_W-1:0];
        [PAIR_T0:PAIR_T2]:    tvec_r[pidx] <= pdiff;
        [PAIR_B0:PAIR_LAST]:  bvec_r[pidx] <= pdiff;
        default:              det_r <= det_r;
      endcase
    end
  end

  assign sts.det_zero = (det_r == '0);

  // Magnitudes and signs of the selected vector, then coarse/fine shifts
  always_comb begin
    any_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      vsel[i] = cmd.vec ? bvec_r[i] : tvec_r[i];
      any_big = any_big | (mag_r[i][VEC_W-1:NORM_B+FAST_SH] != '0);
    end
  end

  assign sts.mag_zero  = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
  assign sts.norm_done = (mag_r[0][VEC_W-1:NORM_B] == '0) &&
                         (mag_r[1][VEC_W-1:NORM_B] == '0) &&
                         (mag_r[2][VEC_W-1:NORM_B] == '0);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.nload) begin
        mag_r[i] <= vsel[i][VEC_W-1] ? VEC_W'(-vsel[i]) : VEC_W'(vsel[i]);
        sgn_r[i] <= vsel[i][VEC_W-1] ^ det_r[DET_W-1];
      end else if (cmd.nshift) begin
        mag_r[i] <= any_big ? (mag_r[i] >> FAST_SH) : (mag_r[i] >> 1);
      end
    end
  end

  // Sum of squares
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_acc) begin
      sum_r <= sum_r + prod_r[SQ_W-1:0];
    end
  end

  // Integer square root, one digit per cycle
  assign trial       = root_r + bit_r;
  assign sts.bit_one = bit_r[0];

  always_ff @(posedge clk) begin
    if (cmd.sinit) begin
      x_r    <= ROOT_W'(sum_r);
      root_r <= '0;
      bit_r  <= ROOT_W'(1) << (ROOT_W - 1);
    end else if (cmd.sstep) begin
      if (x_r >= trial) begin
        x_r    <= x_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign len = root_r[LEN_W-1:0];

  // Rounded division by twice the length, three lanes, one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.dinit) begin
      dsh_r <= REM_W'({len, 1'b0}) << (DIV_STEPS - 1);
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= (REM_W'(mag_r[i][NORM_B-1:0]) << (DIV_STEPS)) + REM_W'(len);
        q_r[i]   <= '0;
      end
    end else if (cmd.dstep) begin
      dsh_r <= dsh_r >> 1;
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= dsh_r) begin
          rem_r[i] <= rem_r[i] - dsh_r;
          q_r[i]   <= {q_r[i][QUO_W-2:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // Apply signs and store the unit vector
  always_ff @(posedge clk) begin
    if (cmd.dstore) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd.vec) begin
          bun_r[i] <= sgn_r[i] ? -$signed({1'b0, q_r[i]}) : $signed({1'b0, q_r[i]});
        end else begin
          tun_r[i] <= sgn_r[i] ? -$signed({1'b0, q_r[i]}) : $signed({1'b0, q_r[i]});
        end
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tangent_x    <= cmd.deg ? '0 : tun_r[0];
      tangent_y    <= cmd.deg ? '0 : tun_r[1];
      tangent_z    <= cmd.deg ? '0 : tun_r[2];
      bitangent_x  <= cmd.deg ? '0 : bun_r[0];
      bitangent_y  <= cmd.deg ? '0 : bun_r[1];
      bitangent_z  <= cmd.deg ? '0 : bun_r[2];
      degenerate   <= cmd.deg;
      out_corner_a <= corner_r[0];
      out_corner_b <= corner_r[1];
      out_corner_c <= corner_r[2];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ttb_ctrl.sv =====
`default_nettype none

module ttb_ctrl import ttb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_func,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ttb_sts_t sts,
  output ttb_cmd_t cmd
);

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_RD_A   = 22'h000002,
    S_RD_B   = 22'h000004,
    S_RD_C   = 22'h000008,
    S_RD_W   = 22'h000010,
    S_DIFF   = 22'h000020,
    S_MUL0   = 22'h000040,
    S_MUL1   = 22'h000080,
    S_MWR    = 22'h000100,
    S_DCHK   = 22'h000200,
    S_NLOAD  = 22'h000400,
    S_NSHIFT = 22'h000800,
    S_SQ0    = 22'h001000,
    S_SQ1    = 22'h002000,
    S_SQ2    = 22'h004000,
    S_SQA    = 22'h008000,
    S_SINIT  = 22'h010000,
    S_SQRT   = 22'h020000,
    S_DINIT  = 22'h040000,
    S_DIV    = 22'h080000,
    S_DSTORE = 22'h100000,
    S_FINISH = 22'h200000
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       pair_r, pair_nxt;
  logic             vec_r, vec_nxt;
  logic [CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic             deg_r, deg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Write load words to the store; sequence one triangle through fetch, products, and two normalizations
  always_comb begin
    state_nxt = state_r;
    pair_nxt  = pair_r;
    vec_nxt   = vec_r;
    dcnt_nxt  = dcnt_r;
    deg_nxt   = deg_r;
    cmd       = '0;
    cmd.pair  = pair_r;
    cmd.vec   = vec_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func) begin
            cmd.tri_load = 1'b1;
            deg_nxt      = 1'b0;
            state_nxt    = S_RD_A;
          end else begin
            cmd.vtx_wr = 1'b1;
          end
        end
      end
      S_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 2'd1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd0;
        state_nxt   = S_RD_C;
      end
      S_RD_C: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 2'd2;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd1;
        state_nxt   = S_RD_W;
      end
      S_RD_W: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd2;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        pair_nxt    = PAIR_DET;
        state_nxt   = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.half   = 1'b1;
        state_nxt  = S_MWR;
      end
      S_MWR: begin
        cmd.mwr = 1'b1;
        if (pair_r == PAIR_LAST) begin
          state_nxt = S_DCHK;
        end else begin
          pair_nxt  = pair_r + 3'd1;
          state_nxt = S_MUL0;
        end
      end
      S_DCHK: begin
        vec_nxt = 1'b0;
        if (sts.det_zero) begin
          deg_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_NLOAD;
        end
      end
      S_NLOAD: begin
        cmd.nload = 1'b1;
        state_nxt = S_NSHIFT;
      end
      S_NSHIFT: begin
        if (sts.mag_zero) begin
          deg_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.norm_done) begin
          state_nxt = S_SQ0;
        end else begin
          cmd.nshift = 1'b1;
        end
      end
      S_SQ0: begin
        cmd.mul_en  = 1'b1;
        cmd.sq_mode = 1'b1;
        cmd.sq_idx  = 2'd0;
        cmd.sum_clr = 1'b1;
        state_nxt   = S_SQ1;
      end
      S_SQ1: begin
        cmd.mul_en  = 1'b1;
        cmd.sq_mode = 1'b1;
        cmd.sq_idx  = 2'd1;
        cmd.sum_acc = 1'b1;
        state_nxt   = S_SQ2;
      end
      S_SQ2: begin
        cmd.mul_en  = 1'b1;
        cmd.sq_mode = 1'b1;
        cmd.sq_idx  = 2'd2;
        cmd.sum_acc = 1'b1;
        state_nxt   = S_SQA;
      end
      S_SQA: begin
        cmd.sum_acc = 1'b1;
        state_nxt   = S_SINIT;
      end
      S_SINIT: begin
        cmd.sinit = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sstep = 1'b1;
        if (sts.bit_one) begin
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        dcnt_nxt  = dcnt_r + CNT_W'(1);
        if (dcnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.dstore = 1'b1;
        if (vec_r) begin
          state_nxt = S_FINISH;
        end else begin
          vec_nxt   = 1'b1;
          state_nxt = S_NLOAD;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          cmd.deg      = deg_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pair_r      <= '0;
      vec_r       <= 1'b0;
      dcnt_r      <= '0;
      deg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pair_r      <= pair_nxt;
      vec_r       <= vec_nxt;
      dcnt_r      <= dcnt_nxt;
      deg_r       <= deg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_tri_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid && in_func) |=> (state_r == S_RD_A))
    else $error("triangle word accepted without starting fetch");

  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && (!out_valid_r || out_tready)) |=>
    (out_valid_r && state_r == S_IDLE))
    else $error("finished triangle did not produce an output word");

  a_second_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTORE && !vec_r) |=> (state_r == S_NLOAD && vec_r))
    else $error("bitangent pass not started after tangent");

endmodule

`default_nettype wire

// ===== sv/triangle_tangent_basis.sv =====
// Per-triangle tangent and bitangent unit.
// Input channel (in_*): in_tuser selects the word kind. A load word (0)
// writes one vertex (position Q16.16, texture coordinate Q2.16) into the
// vertex store. A triangle word (1) names three corners and yields one
// output word.
// Output channel (out_*): tangent and bitangent as Q2.14 unit vectors plus
// the three corner indices; out_tuser flags a degenerate triangle, which
// carries zero vectors.
// A triangle runs through the square root loop (one digit per cycle) and the
// bit-serial rounding divider, both once for the tangent and once for the
// bitangent, plus the products on the single shared multiplier and the
// scaling shifts of each vector. A zero determinant or a zero vector ends
// the triangle early. The block takes one word at a time; a new word is
// accepted once the previous triangle has moved into the output register.
// Reset clears the controller and the output valid; the vertex store is not
// cleared and holds no data until loaded. While the receiver stalls the
// output word holds, loads still proceed, and a following triangle waits
// in its last step until the output register is free.
`default_nettype none

module triangle_tangent_basis import ttb_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vertex_index[9:0] pos_x[41:10] pos_y[73:42] pos_z[105:74]
  // tex_u[123:106] tex_v[141:124] corner_a[151:142] corner_b[161:152]
  // corner_c[171:162], zero above
  input  logic [175:0] in_tdata,
  // func[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tangent_x[15:0] tangent_y[31:16] tangent_z[47:32] bitangent_x[63:48]
  // bitangent_y[79:64] bitangent_z[95:80] out_corner_a[105:96]
  // out_corner_b[115:106] out_corner_c[125:116], zero above
  output logic [127:0] out_tdata,
  // degenerate[0]
  output logic         out_tuser
);

  ttb_cmd_t cmd;
  ttb_sts_t sts;

  logic signed [UNIT_W-1:0] tx, ty, tz, bx, by, bz;
  logic [IDX_W-1:0]         oca, ocb, occ;

  ttb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ttb_dp #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_dp (
    .clk          (clk),
    .vertex_index (in_tdata[9:0]),
    .pos_x        (in_tdata[41:10]),
    .pos_y        (in_tdata[73:42]),
    .pos_z        (in_tdata[105:74]),
    .tex_u        (in_tdata[123:106]),
    .tex_v        (in_tdata[141:124]),
    .corner_a     (in_tdata[151:142]),
    .corner_b     (in_tdata[161:152]),
    .corner_c     (in_tdata[171:162]),
    .cmd          (cmd),
    .sts          (sts),
    .tangent_x    (tx),
    .tangent_y    (ty),
    .tangent_z    (tz),
    .bitangent_x  (bx),
    .bitangent_y  (by),
    .bitangent_z  (bz),
    .degenerate   (out_tuser),
    .out_corner_a (oca),
    .out_corner_b (ocb),
    .out_corner_c (occ)
  );

  // Pack the output word
  assign out_tdata = {2'b00, occ, ocb, oca, bz, by, bx, tz, ty, tx};

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

  localparam int DEPTH = 1024;
  localparam int N_RANDOM = 1550;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef enum logic {FUNC_LOAD = 1'b0, FUNC_TRI = 1'b1} func_e;

  typedef struct packed {
    logic [15:0] tx, ty, tz, bx, by, bz;
    logic        degen;
    logic [9:0]  ca, cb, cc;
  } basis_t;

  typedef struct {
    func_e       func;
    logic [9:0]  slot;
    logic [31:0] px, py, pz;
    logic [17:0] u, v;
    logic [9:0]  ca, cb, cc;
    logic        has_fixed;
    basis_t      fixed;
  } word_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [175:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [127:0] out_tdata;

  triangle_tangent_basis u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Mirror of the vertex store
  logic signed [31:0] vx [DEPTH];
  logic signed [31:0] vy [DEPTH];
  logic signed [31:0] vz [DEPTH];
  logic signed [17:0] vu [DEPTH];
  logic signed [17:0] vv [DEPTH];
  bit written [DEPTH];
  int written_list[$];

  basis_t pending_basis[$];
  int errors;
  int n_tri, n_load, n_degen;
  longint cycles;
  int send_idle, recv_idle;
  bit hold_recv;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("triangle_tangent_basis test failed");
      $finish;
    end
  end

  // Unit vector in Q2.14, rounded half away from zero
  function automatic bit unit_vec(input longint vin[3], output logic [15:0] res[3]);
    longint unsigned mag[3], mx, sum, len, x, r, b, q;
    int s;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vin[i] < 0 ? -vin[i] : vin[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 0;
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      sum += mag[i] * mag[i];
    end
    // integer square root
    x = sum; r = 0; b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    len = r;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 32768 + len) / (2 * len);
      res[i] = vin[i] < 0 ? 16'(-longint'(q)) : 16'(q);
    end
    return 1;
  endfunction

  function automatic basis_t tangent_basis(input logic [9:0] a, b, c);
    basis_t r;
    longint pa[3], pb[3], pc[3], e1[3], e2[3], tv[3], bv[3];
    longint ua, va, ub, vb, uc, vc, du1, dv1, du2, dv2, det;
    logic [15:0] tu[3], bu[3];
    bit degen;
    pa = '{vx[a], vy[a], vz[a]}; pb = '{vx[b], vy[b], vz[b]}; pc = '{vx[c], vy[c], vz[c]};
    ua = vu[a]; va = vv[a]; ub = vu[b]; vb = vv[b]; uc = vu[c]; vc = vv[c];
    du1 = ub - ua; dv1 = vb - va; du2 = uc - ua; dv2 = vc - va;
    det = du1 * dv2 - dv1 * du2;
    for (int i = 0; i < 3; i++) begin
      e1[i] = pb[i] - pa[i];
      e2[i] = pc[i] - pa[i];
      tv[i] = dv2 * e1[i] - dv1 * e2[i];
      bv[i] = du1 * e2[i] - du2 * e1[i];
      if (det < 0) begin
        tv[i] = -tv[i];
        bv[i] = -bv[i];
      end
    end
    degen = (det == 0);
    if (!degen) degen = !unit_vec(tv, tu);
    if (!degen) degen = !unit_vec(bv, bu);
    if (degen) begin
      tu = '{16'd0, 16'd0, 16'd0};
      bu = '{16'd0, 16'd0, 16'd0};
    end
    r.tx = tu[0]; r.ty = tu[1]; r.tz = tu[2];
    r.bx = bu[0]; r.by = bu[1]; r.bz = bu[2];
    r.degen = degen; r.ca = a; r.cb = b; r.cc = c;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got, exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    errors++;
  endtask

  // Compare each output word with the oldest pending basis
  always @(posedge clk) begin
    basis_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_basis.size() == 0) begin
        $display("output word with nothing pending");
        errors++;
      end else begin
        e = pending_basis.pop_front();
        if (out_tdata[15:0] !== e.tx) report_mismatch("tangent_x", out_tdata[15:0], e.tx);
        if (out_tdata[31:16] !== e.ty) report_mismatch("tangent_y", out_tdata[31:16], e.ty);
        if (out_tdata[47:32] !== e.tz) report_mismatch("tangent_z", out_tdata[47:32], e.tz);
        if (out_tdata[63:48] !== e.bx) report_mismatch("bitangent_x", out_tdata[63:48], e.bx);
        if (out_tdata[79:64] !== e.by) report_mismatch("bitangent_y", out_tdata[79:64], e.by);
        if (out_tdata[95:80] !== e.bz) report_mismatch("bitangent_z", out_tdata[95:80], e.bz);
        if (out_tuser !== e.degen) report_mismatch("degenerate", 16'(out_tuser), 16'(e.degen));
        if (out_tdata[105:96] !== e.ca) report_mismatch("corner_a", 16'(out_tdata[105:96]), 16'(e.ca));
        if (out_tdata[115:106] !== e.cb) report_mismatch("corner_b", 16'(out_tdata[115:106]), 16'(e.cb));
        if (out_tdata[125:116] !== e.cc) report_mismatch("corner_c", 16'(out_tdata[125:116]), 16'(e.cc));
        if (out_tdata[127:126] !== 2'b00) report_mismatch("pad", 16'(out_tdata[127:126]), 16'd0);
      end
    end
  end

  // Receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_recv) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Offer one word; valid stays high after acceptance until the next word or idle
  task automatic send_word(input word_t w);
    basis_t e;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.func;
    in_tdata <= {4'd0, w.cc, w.cb, w.ca, w.v, w.u, w.pz, w.py, w.px, w.slot};
    do @(posedge clk); while (!in_tready);
    if (w.func == FUNC_LOAD) begin
      n_load++;
      vx[w.slot] = w.px; vy[w.slot] = w.py; vz[w.slot] = w.pz;
      vu[w.slot] = w.u; vv[w.slot] = w.v;
      if (!written[w.slot]) begin
        written[w.slot] = 1;
        written_list = {written_list, int'(w.slot)};
      end
    end else begin
      n_tri++;
      e = tangent_basis(w.ca, w.cb, w.cc);
      if (w.has_fixed && e !== w.fixed) begin
        $display("predictor disagrees with directed row for corners %0d %0d %0d",
                 w.ca, w.cb, w.cc);
        errors++;
      end
      if (e.degen) n_degen++;
      pending_basis = {pending_basis, e};
    end
  endtask

  function automatic word_t mk_load(input logic [9:0] s, input logic [31:0] x, y, z,
                                    input logic [17:0] u, v);
    word_t w;
    w.func = FUNC_LOAD; w.slot = s; w.px = x; w.py = y; w.pz = z; w.u = u; w.v = v;
    w.ca = 10'($urandom); w.cb = 10'($urandom); w.cc = 10'($urandom);
    w.has_fixed = 0; w.fixed = '0;
    return w;
  endfunction

  function automatic word_t mk_tri(input logic [9:0] a, b, c);
    word_t w;
    w.func = FUNC_TRI; w.ca = a; w.cb = b; w.cc = c;
    w.slot = 10'($urandom); w.px = $urandom; w.py = $urandom; w.pz = $urandom;
    w.u = 18'($urandom); w.v = 18'($urandom);
    w.has_fixed = 0; w.fixed = '0;
    return w;
  endfunction

  function automatic logic [9:0] pick_written();
    return 10'(written_list[$urandom_range(written_list.size() - 1)]);
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(65536 * 64)) - 65536 * 32);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1000)) - 500);
    endcase
  endfunction

  function automatic logic [17:0] rand_tex();
    case ($urandom_range(3))
      0: return 18'($urandom);
      1: return 18'($urandom_range(65536));
      2: return $urandom_range(1) ? 18'h1ffff : 18'h20000;
      default: return 18'($signed($urandom_range(20)) - 10);
    endcase
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_basis.size() != 0) @(posedge clk);
    while (guard < 200) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic run_random(input int count);
    word_t w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 45 || written_list.size() < 3) begin
        // mostly reuse a few slots so triangles hit fresh data
        w = mk_load($urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(15)),
                    rand_pos(), rand_pos(), rand_pos(), rand_tex(), rand_tex());
      end else begin
        case ($urandom_range(9))
          0: w = mk_tri(pick_written(), pick_written(), 10'($urandom_range(1023)) | 10'h0);
          default: w = mk_tri(pick_written(), pick_written(), pick_written());
        endcase
        if (!written[w.cc]) w.cc = pick_written();
      end
      send_word(w);
    end
  endtask

  // Directed rows: loads and triangles for a unit triangle, extremes and degenerate cases
  word_t table_rows[$];
  initial begin
    word_t w;
    basis_t f;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    rst_n = 1'b0; errors = 0; cycles = 0; hold_recv = 0;
    n_tri = 0; n_load = 0; n_degen = 0;
    send_idle = 31; recv_idle = 77;

    // unit right triangle: T = +x, B = +y
    table_rows = {table_rows, mk_load(10'd0, 32'd0, 32'd0, 32'd0, 18'd0, 18'd0)};
    table_rows = {table_rows, mk_load(10'd1, 32'h00010000, 32'd0, 32'd0, 18'h10000, 18'd0)};
    table_rows = {table_rows, mk_load(10'd2, 32'd0, 32'h00010000, 32'd0, 18'd0, 18'h10000)};
    w = mk_tri(10'd0, 10'd1, 10'd2);
    f = '{16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 1'b0, 10'd0, 10'd1, 10'd2};
    w.has_fixed = 1; w.fixed = f;
    table_rows = {table_rows, w};
    // all corners the same: degenerate
    w = mk_tri(10'd1, 10'd1, 10'd1);
    w.has_fixed = 1; w.fixed = '{0, 0, 0, 0, 0, 0, 1'b1, 10'd1, 10'd1, 10'd1};
    table_rows = {table_rows, w};
    // extremes of every field
    table_rows = {table_rows, mk_load(10'd1023, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                      18'h1ffff, 18'h20000)};
    table_rows = {table_rows, mk_load(10'd1022, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                      18'h20000, 18'h1ffff)};
    table_rows = {table_rows, mk_load(10'd1021, 32'hffffffff, 32'h00000001, 32'h55555555,
                                      18'h3ffff, 18'h20000)};
    table_rows = {table_rows, mk_tri(10'd1023, 10'd1022, 10'd1021)};
    table_rows = {table_rows, mk_tri(10'd1021, 10'd1023, 10'd1022)};
    table_rows = {table_rows, mk_tri(10'd0, 10'd1023, 10'd1022)};
    // collinear UVs: det zero
    table_rows = {table_rows,
                  mk_load(10'd3, 32'h00020000, 32'h00030000, 32'd5, 18'h08000, 18'h08000)};
    w = mk_tri(10'd0, 10'd3, 10'd3);
    w.has_fixed = 1; w.fixed = '{0, 0, 0, 0, 0, 0, 1'b1, 10'd0, 10'd3, 10'd3};
    table_rows = {table_rows, w};
    // zero-length vector with nonzero det: all positions equal
    table_rows = {table_rows, mk_load(10'd4, 32'd0, 32'd0, 32'd0, 18'h10000, 18'h10000)};
    table_rows = {table_rows, mk_load(10'd5, 32'd0, 32'd0, 32'd0, 18'h3ffff, 18'h10000)};
    w = mk_tri(10'd0, 10'd4, 10'd5);
    w.has_fixed = 1; w.fixed = '{0, 0, 0, 0, 0, 0, 1'b1, 10'd0, 10'd4, 10'd5};
    table_rows = {table_rows, w};
    // negative determinant flips both vectors
    table_rows = {table_rows, mk_tri(10'd0, 10'd2, 10'd1)};
    table_rows = {table_rows, mk_tri(10'd2, 10'd1, 10'd0)};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) send_word(table_rows[i]);

    // long receiver hold-off while the sender keeps going
    fork
      begin
        hold_recv = 1;
        repeat (600) @(posedge clk);
        hold_recv = 0;
      end
      run_random(100);
    join
    run_random(N_RANDOM / 3 - 100);
    send_idle = 77; recv_idle = 31;
    run_random(N_RANDOM / 3);
    send_idle = 0; recv_idle = 0;
    run_random(N_RANDOM - 2 * (N_RANDOM / 3));
    in_tvalid <= 1'b0;
    wait_drained();

    $display("ran %0d loads and %0d triangles, %0d of them degenerate",
             n_load, n_tri, n_degen);
    $display("covered extremes, degenerate cases and a long output stall");
    if (errors == 0) begin
      $display("triangle_tangent_basis test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("triangle_tangent_basis test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
